// ----- sv/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared constants, transaction structs and controller/datapath interface.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int TABLE_SLOTS = 8;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_SEARCH = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] key;
      logic [7:0]  payload;
   } lpht_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] slot;
      logic [7:0] stored_payload;
      logic [3:0] occupied;
   } lpht_rsp_type;

   typedef enum logic [1:0] {
      SEL_NONE,
      SEL_PROBE,
      SEL_READ
   } lpht_slot_sel_type;

   typedef struct packed {
      logic              load;
      logic              advance;
      logic              read;
      logic              write_entry;
      logic              clear_entry;
      logic              respond;
      logic [1:0]        rsp_status;
      lpht_slot_sel_type slot_sel;
      logic              take_payload;
   } lpht_cmd_type;

   typedef struct packed {
      logic full;
      logic slot_free;
      logic probes_done;
      logic hit;
      logic rd_pending;
   } lpht_stat_type;

   function automatic logic [SLOT_W-1:0] home_slot(input logic [7:0] c);
      logic [15:0] v;
      v = {8'd0, c};
      for (int b = 7; b >= 0; b--) begin
         if (v >= (16'(TABLE_SLOTS) << b)) begin
            v = v - (16'(TABLE_SLOTS) << b);
         end
      end
      return v[SLOT_W-1:0];
   endfunction

   function automatic logic [63:0] trim_key(input logic [63:0] k);
      logic [63:0] t;
      logic        live;
      t    = '0;
      live = 1'b1;
      for (int b = 0; b < 8; b++) begin
         live = live & (k[8*b +: 8] != 8'd0);
         if (live) begin
            t[8*b +: 8] = k[8*b +: 8];
         end
      end
      return t;
   endfunction

endpackage

// ----- sv/lpht_ctrl.sv -----
// ----------------------------------------------------------------------------
// Linear probe hash table controller
// Sequences load, probe, update and response steps of one transaction.
// ----------------------------------------------------------------------------
module lpht_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_command,
   input  lpht_pkg::lpht_stat_type stat,
   output lpht_pkg::lpht_cmd_type  cmd,
   output logic                  busy
);
   import lpht_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INSERT,
      S_FIND,
      S_NOP
   } state_type;

   state_type state_ff, state_in;
   logic      del_ff, del_in;

   always_comb begin
      state_in         = state_ff;
      del_in           = del_ff;
      cmd              = '0;
      cmd.rsp_status   = ST_OK;
      cmd.slot_sel     = SEL_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               del_in   = (req_command == CMD_DELETE);
               case (req_command)
                  CMD_INSERT: state_in = S_INSERT;
                  CMD_SEARCH: state_in = S_FIND;
                  CMD_DELETE: state_in = S_FIND;
                  default:    state_in = S_NOP;
               endcase
            end
         end
         S_INSERT: begin
            if (stat.full || (!stat.slot_free && stat.probes_done)) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_FULL;
               state_in       = S_IDLE;
            end else if (stat.slot_free) begin
               cmd.write_entry = 1'b1;
               cmd.respond     = 1'b1;
               cmd.slot_sel    = SEL_PROBE;
               state_in        = S_IDLE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_FIND: begin
            if (stat.hit) begin
               cmd.respond      = 1'b1;
               cmd.slot_sel     = SEL_READ;
               cmd.take_payload = !del_ff;
               cmd.clear_entry  = del_ff;
               state_in         = S_IDLE;
            end else if (stat.probes_done) begin
               if (!stat.rd_pending) begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = ST_MISSING;
                  state_in       = S_IDLE;
               end
            end else begin
               cmd.read    = 1'b1;
               cmd.advance = 1'b1;
            end
         end
         S_NOP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         del_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         del_ff   <= del_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   assert property (@(posedge clock) disable iff (reset)
      (cmd.write_entry || cmd.clear_entry) |-> cmd.respond)
      else $error("table update without response");

   assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> (state_ff == S_IDLE))
      else $error("controller not idle after response");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

endmodule

// ----- sv/lpht_datapath.sv -----
// ----------------------------------------------------------------------------
// Linear probe hash table datapath
// Slot storage, valid bits, fill count, probe pointer and response register.
// ----------------------------------------------------------------------------
module lpht_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  lpht_pkg::lpht_req_type  req_data,
   input  lpht_pkg::lpht_cmd_type  cmd,
   output lpht_pkg::lpht_stat_type stat,
   output lpht_pkg::lpht_rsp_type  rsp_data,
   output logic                   rsp_strobe
);
   import lpht_pkg::*;

   logic [63:0]            key_mem_ff [TABLE_SLOTS];
   logic [7:0]             pay_mem_ff [TABLE_SLOTS];

   logic [63:0]            key_ff, key_in;
   logic [7:0]             pay_ff, pay_in;
   logic [SLOT_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]       probe_ff, probe_in;
   logic [TABLE_SLOTS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [63:0]            rd_key_ff;
   logic [7:0]             rd_pay_ff;
   logic [SLOT_W-1:0]      rd_slot_ff;
   logic                   rd_live_ff;
   logic                   rd_pend_ff, rd_pend_in;
   lpht_rsp_type           rsp_ff, rsp_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [SLOT_W-1:0]      ptr_next;

   assign ptr_next = (ptr_ff == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : ptr_ff + 1'b1;

   always_comb begin
      key_in   = key_ff;
      pay_in   = pay_ff;
      ptr_in   = ptr_ff;
      probe_in = probe_ff;
      if (cmd.load) begin
         key_in   = trim_key(req_data.key);
         pay_in   = req_data.payload;
         ptr_in   = home_slot(req_data.key[7:0]);
         probe_in = '0;
      end else if (cmd.advance) begin
         ptr_in   = ptr_next;
         probe_in = probe_ff + 1'b1;
      end

      valid_in = valid_ff;
      if (cmd.write_entry) begin
         valid_in[ptr_ff] = 1'b1;
      end
      if (cmd.clear_entry) begin
         valid_in[rd_slot_ff] = 1'b0;
      end
      fill_in = fill_ff + CNT_W'(cmd.write_entry) - CNT_W'(cmd.clear_entry);

      rd_pend_in = cmd.read;

      rsp_in        = rsp_ff;
      rsp_strobe_in = cmd.respond;
      if (cmd.respond) begin
         rsp_in.status = cmd.rsp_status;
         case (cmd.slot_sel)
            SEL_PROBE: rsp_in.slot = 3'(ptr_ff);
            SEL_READ:  rsp_in.slot = 3'(rd_slot_ff);
            default:   rsp_in.slot = 3'd0;
         endcase
         rsp_in.stored_payload = cmd.take_payload ? rd_pay_ff : 8'd0;
         rsp_in.occupied       = 4'(fill_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         fill_ff       <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         fill_ff       <= fill_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      pay_ff   <= pay_in;
      ptr_ff   <= ptr_in;
      probe_ff <= probe_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         key_mem_ff[ptr_ff] <= key_ff;
         pay_mem_ff[ptr_ff] <= pay_ff;
      end
      if (cmd.read) begin
         rd_key_ff  <= key_mem_ff[ptr_ff];
         rd_pay_ff  <= pay_mem_ff[ptr_ff];
         rd_slot_ff <= ptr_ff;
         rd_live_ff <= valid_ff[ptr_ff];
      end
   end

   assign stat.full        = (fill_ff >= CNT_W'(TABLE_SLOTS));
   assign stat.slot_free   = !valid_ff[ptr_ff];
   assign stat.probes_done = (probe_ff == CNT_W'(TABLE_SLOTS));
   assign stat.hit         = rd_pend_ff && rd_live_ff && (rd_key_ff == key_ff);
   assign stat.rd_pending  = rd_pend_ff;

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = rsp_strobe_ff;

   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(fill_ff))
      else $error("fill count differs from valid slot count");

   assert property (@(posedge clock) disable iff (reset)
      cmd.write_entry |-> !valid_ff[ptr_ff])
      else $error("insert over an occupied slot");

   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_entry |-> valid_ff[rd_slot_ff])
      else $error("delete of an empty slot");

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(TABLE_SLOTS))
      else $error("fill count above slot count");

endmodule

// ----- sv/linear_probe_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// Linear probe hash table core
// Open-addressing table with linear probing: insert, search and delete.
//
//   channel   ports                         handshake
//   request   start, busy, req_data         taken when start & !busy
//   response  rsp_strobe, rsp_data          valid for one cycle, no stall
//
// One transaction at a time; busy stays high from acceptance until the
// cycle in which rsp_strobe rises, where the next start is taken.
// Insert probes one valid bit per cycle from the home slot; search and
// delete read one slot per cycle from the slot memory and compare each
// registered read against the request key.
// Synchronous reset empties the table by clearing all valid bits.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lpht_pkg::lpht_req_type req_data,
   output logic                  rsp_strobe,
   output lpht_pkg::lpht_rsp_type rsp_data
);
   import lpht_pkg::*;

   lpht_cmd_type  cmd;
   lpht_stat_type stat;

   lpht_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_data.command),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy)
   );

   lpht_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Linear probe hash table core testbench
// Drives insert, search and delete transactions into the core through the
// start/busy handshake. A directed table fills the table, overflows it and
// exercises duplicates, inner-zero keys, misses and the unused command. A
// long random run with a small key pool follows, under several idle
// patterns. Every response is checked field by field against a table model
// kept in the testbench, or against a fixed response given in a directed row.
// ----------------------------------------------------------------------------
module tb_top;
   import lpht_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 750;
   localparam int         POOL_SIZE    = 12;
   localparam int         CYCLE_LIMIT  = 200000;

   typedef struct {
      lpht_req_type req;
      bit           fixed;
      lpht_rsp_type rsp;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   lpht_req_type req_data;
   logic         rsp_strobe;
   lpht_rsp_type rsp_data;

   logic         tbl_valid   [TABLE_SLOTS];
   logic [63:0]  tbl_key     [TABLE_SLOTS];
   logic [7:0]   tbl_payload [TABLE_SLOTS];
   int           tbl_count;

   lpht_rsp_type pending_rsp [$];
   stim_row_type stim_rows   [$];
   logic [63:0]  key_pool    [POOL_SIZE];

   int n_insert, n_search, n_delete, n_unused, n_full, n_missing;
   int n_checked, mismatches;

   linear_probe_hash_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic logic [63:0] key_significant(logic [63:0] k);
      logic [63:0] out;
      bit          live;
      out  = '0;
      live = 1'b1;
      for (int b = 0; b < 8; b++) begin
         if (k[8*b +: 8] == 8'd0) live = 1'b0;
         if (live) out[8*b +: 8] = k[8*b +: 8];
      end
      return out;
   endfunction

   function automatic lpht_rsp_type table_predict(lpht_req_type r);
      lpht_rsp_type res;
      logic [63:0]  k;
      int           pos;
      int           hit;
      res = '0;
      k   = key_significant(r.key);
      pos = int'(k[7:0]) % TABLE_SLOTS;
      hit = -1;
      case (r.command)
         CMD_INSERT: begin
            n_insert++;
            if (tbl_count < TABLE_SLOTS) begin
               for (int n = 0; n < TABLE_SLOTS && hit < 0; n++) begin
                  if (!tbl_valid[pos]) hit = pos;
                  else pos = (pos + 1) % TABLE_SLOTS;
               end
            end
            if (hit < 0) begin
               res.status = ST_FULL;
               n_full++;
            end else begin
               tbl_valid[hit]   = 1'b1;
               tbl_key[hit]     = k;
               tbl_payload[hit] = r.payload;
               tbl_count++;
               res.status = ST_OK;
               res.slot   = 3'(hit);
            end
         end
         CMD_SEARCH, CMD_DELETE: begin
            if (r.command == CMD_SEARCH) n_search++;
            else n_delete++;
            for (int n = 0; n < TABLE_SLOTS && hit < 0; n++) begin
               if (tbl_valid[pos] && tbl_key[pos] == k) hit = pos;
               else pos = (pos + 1) % TABLE_SLOTS;
            end
            if (hit < 0) begin
               res.status = ST_MISSING;
               n_missing++;
            end else begin
               res.status = ST_OK;
               res.slot   = 3'(hit);
               if (r.command == CMD_SEARCH) begin
                  res.stored_payload = tbl_payload[hit];
               end else begin
                  tbl_valid[hit] = 1'b0;
                  if (tbl_count > 0) tbl_count--;
               end
            end
         end
         default: begin
            n_unused++;
         end
      endcase
      res.occupied = 4'(tbl_count);
      return res;
   endfunction

   task automatic report_mismatch(string what, lpht_rsp_type want, lpht_rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected status=%0d slot=%0d payload=%02h occupied=%0d",
                  what, want.status, want.slot, want.stored_payload, want.occupied);
         $display("   got      status=%0d slot=%0d payload=%02h occupied=%0d",
                  got.status, got.slot, got.stored_payload, got.occupied);
      end
   endtask

   always @(posedge clock) begin
      lpht_rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with no transaction outstanding", '0, rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            n_checked++;
            if (rsp_data.status !== want.status || rsp_data.slot !== want.slot ||
                rsp_data.stored_payload !== want.stored_payload ||
                rsp_data.occupied !== want.occupied) begin
               report_mismatch($sformatf("response %0d mismatch", n_checked), want, rsp_data);
            end
         end
      end
   end

   task automatic send_request(lpht_req_type r, bit fixed, lpht_rsp_type fixed_rsp);
      lpht_rsp_type predicted;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = table_predict(r);
      pending_rsp.push_back(fixed ? fixed_rsp : predicted);
   endtask

   task automatic hold_off(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= '{command: 2'($urandom), key: {$urandom, $urandom},
                       payload: 8'($urandom)};
      end
   endtask

   task automatic drain_pause();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(logic [1:0] cmd, logic [63:0] k, logic [7:0] pay,
                          bit fixed, lpht_rsp_type rsp);
      stim_row_type row;
      row.req   = '{command: cmd, key: k, payload: pay};
      row.fixed = fixed;
      row.rsp   = rsp;
      stim_rows.push_back(row);
   endtask

   function automatic logic [63:0] make_pool_key();
      logic [63:0] k;
      int          len;
      k   = '0;
      len = $urandom_range(1, 8);
      for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
      return k;
   endfunction

   function automatic logic [63:0] pick_key();
      logic [63:0] k;
      int          len;
      if ($urandom_range(0, 99) < 70) begin
         k   = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         len = 0;
         while (len < 8 && k[8*len +: 8] != 8'd0) len++;
         if (len < 7 && $urandom_range(0, 1) == 1) begin
            for (int b = len + 1; b < 8; b++) k[8*b +: 8] = 8'($urandom);
         end
      end else begin
         k = {$urandom, $urandom};
      end
      return k;
   endfunction

   initial begin
      lpht_rsp_type none;
      lpht_req_type r;
      int           n_counted;
      int           phase;
      int           last_phase;
      int           ins_pct;
      int           sel;
      int           idle_pct [4];

      none       = '0;
      idle_pct   = '{0, 67, 0, 33};
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      tbl_count  = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         tbl_valid[i]   = 1'b0;
         tbl_key[i]     = '0;
         tbl_payload[i] = '0;
      end
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = make_pool_key();

      // fill every slot before any lookup so no unwritten entry is ever compared
      add_row(CMD_INSERT, 64'h41, 8'h00, 1'b1,
              '{status: ST_OK, slot: 3'd1, stored_payload: 8'h00, occupied: 4'd1});
      add_row(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1,
              '{status: ST_OK, slot: 3'd7, stored_payload: 8'h00, occupied: 4'd2});
      add_row(CMD_INSERT, 64'h01, 8'h01, 1'b0, none);
      add_row(CMD_INSERT, 64'h0000_4242_0000_0043, 8'h5A, 1'b0, none);
      add_row(CMD_INSERT, 64'h41, 8'h3C, 1'b0, none);
      add_row(CMD_INSERT, 64'h08, 8'h80, 1'b0, none);
      add_row(CMD_INSERT, 64'h80, 8'h7F, 1'b0, none);
      add_row(CMD_INSERT, 64'h7F, 8'hC3, 1'b0, none);
      add_row(CMD_INSERT, 64'h42, 8'h11, 1'b1,
              '{status: ST_FULL, slot: 3'd0, stored_payload: 8'h00, occupied: 4'd8});
      add_row(CMD_SEARCH, 64'h41, 8'h00, 1'b0, none);
      add_row(CMD_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, none);
      add_row(CMD_SEARCH, 64'h0000_9999_0000_0043, 8'h00, 1'b0, none);
      add_row(CMD_SEARCH, 64'h4141, 8'h00, 1'b1,
              '{status: ST_MISSING, slot: 3'd0, stored_payload: 8'h00, occupied: 4'd8});
      add_row(CMD_UNUSED, 64'h41, 8'hA5, 1'b1,
              '{status: ST_OK, slot: 3'd0, stored_payload: 8'h00, occupied: 4'd8});
      add_row(CMD_DELETE, 64'h41, 8'h00, 1'b0, none);
      add_row(CMD_SEARCH, 64'h41, 8'h00, 1'b0, none);
      add_row(CMD_DELETE, 64'h41, 8'h00, 1'b0, none);
      add_row(CMD_DELETE, 64'h41, 8'h00, 1'b1,
              '{status: ST_MISSING, slot: 3'd0, stored_payload: 8'h00, occupied: 4'd6});
      add_row(CMD_INSERT, 64'h00, 8'hE7, 1'b0, none);
      add_row(CMD_SEARCH, 64'hFF00, 8'h00, 1'b0, none);
      add_row(CMD_DELETE, 64'hAB00, 8'h00, 1'b0, none);
      add_row(CMD_SEARCH, 64'h0000_4242_0000_0043, 8'h00, 1'b0, none);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) send_request(stim_rows[i].req, stim_rows[i].fixed, stim_rows[i].rsp);
      drain_pause();

      n_counted  = 0;
      last_phase = 0;
      ins_pct    = 50;
      while (n_counted < RANDOM_ITEMS) begin
         phase = n_counted * 4 / RANDOM_ITEMS;
         if (phase != last_phase) begin
            drain_pause();
            last_phase = phase;
         end
         if ($urandom_range(0, 39) == 0) ins_pct = $urandom_range(15, 75);
         if ($urandom_range(0, 99) < idle_pct[phase]) hold_off($urandom_range(1, 4));
         r.key     = pick_key();
         r.payload = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < 5) begin
            r.command = CMD_UNUSED;
         end else begin
            sel = $urandom_range(0, 99);
            if (sel < ins_pct) r.command = CMD_INSERT;
            else if (sel < ins_pct + (100 - ins_pct) / 2) r.command = CMD_SEARCH;
            else r.command = CMD_DELETE;
         end
         send_request(r, 1'b0, none);
         if (r.command != CMD_UNUSED) n_counted++;
      end

      drain_pause();
      repeat (TABLE_SLOTS + 8) @(posedge clock);

      $display("Covered %0d inserts, %0d searches, %0d deletes and %0d unused commands;",
               n_insert, n_search, n_delete, n_unused);
      $display("%0d table-full rejections, %0d missing keys, %0d responses checked.",
               n_full, n_missing, n_checked);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         if (pending_rsp.size() != 0)
            $display("%0d expected responses never arrived", pending_rsp.size());
         $display("%0d mismatches", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles", CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/lpht_pkg.sv
sv/lpht_ctrl.sv
sv/lpht_datapath.sv
sv/linear_probe_hash_table_core.sv
tb/tb_top.sv
